// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/abd_pkg.sv =====
// ---------------------------------------------------------------------------
// abd_pkg
// Types and constants for the Adler-32 / FNV-1a 64 block digest.
// ---------------------------------------------------------------------------
package abd_pkg;

    localparam int unsigned SUM_W  = 16;
    localparam int unsigned HASH_W = 64;

    localparam logic [SUM_W-1:0]  ADLER_MOD      = 16'd65521;
    localparam logic [SUM_W-1:0]  LOW_SUM_INIT   = 16'd1;
    localparam logic [SUM_W-1:0]  HIGH_SUM_INIT  = 16'd0;
    localparam logic [HASH_W-1:0] FNV_BASIS      = 64'hCBF2_9CE4_8422_2325;

    typedef struct packed {
        logic [SUM_W-1:0]  low_sum;
        logic [SUM_W-1:0]  high_sum;
        logic [HASH_W-1:0] fnv_state;
    } abd_state_t;

    localparam abd_state_t STATE_INIT = '{
        low_sum:   LOW_SUM_INIT,
        high_sum:  HIGH_SUM_INIT,
        fnv_state: FNV_BASIS
    };

endpackage

// ===== hdl/abd_update.sv =====
// ---------------------------------------------------------------------------
// abd_update
// Advances both Adler-32 sums and the FNV-1a 64 hash by one byte.
// ---------------------------------------------------------------------------
module abd_update
(
    input  abd_pkg::abd_state_t state_cur,
    input  logic [7:0]          data_byte,
    output abd_pkg::abd_state_t state_upd
);
    import abd_pkg::*;

    logic [SUM_W:0]    low_raw;
    logic [SUM_W:0]    high_raw;
    logic [SUM_W-1:0]  low_new;
    logic [SUM_W-1:0]  high_new;
    logic [HASH_W-1:0] fnv_mix;

    assign low_raw = {1'b0, state_cur.low_sum} + {9'd0, data_byte};
    assign low_new = (low_raw >= {1'b0, ADLER_MOD})
                   ? SUM_W'(low_raw - {1'b0, ADLER_MOD}) : low_raw[SUM_W-1:0];

    assign high_raw = {1'b0, state_cur.high_sum} + {1'b0, low_new};
    assign high_new = (high_raw >= {1'b0, ADLER_MOD})
                    ? SUM_W'(high_raw - {1'b0, ADLER_MOD}) : high_raw[SUM_W-1:0];

    assign fnv_mix = state_cur.fnv_state ^ {56'd0, data_byte};

    // multiply by the FNV prime 2^40 + 0x1B3
    always_comb
    begin
        state_upd.low_sum   = low_new;
        state_upd.high_sum  = high_new;
        state_upd.fnv_state = (fnv_mix << 40) + (fnv_mix << 8) + (fnv_mix << 7)
                            + (fnv_mix << 5) + (fnv_mix << 4) + (fnv_mix << 1) + fnv_mix;
    end

endmodule

// ===== hdl/block_adler_fnv_digest_top.sv =====
// ---------------------------------------------------------------------------
// block_adler_fnv_digest_top
// Byte-stream block digest: Adler-32 checksum and FNV-1a 64 hash per block.
// ---------------------------------------------------------------------------
// Channel  Signals                               Request
// in       in_valid/in_ready                     data_byte, block_end
// out      out_valid/out_ready                   weak_checksum, strong_hash
//
// One byte per cycle sustained while the result register is free; a byte
// is held in the input register and folded into the digest state as it leaves.
// A marked byte's digests go from the input register into the result register.
// Reset returns the sums to 1 and 0 and the hash to the offset basis.
// A marked byte waits in the input register while the result register is full.
// ---------------------------------------------------------------------------
module block_adler_fnv_digest_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        block_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] weak_checksum,
    output logic [63:0] strong_hash
);
    import abd_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;

    abd_state_t state_reg;
    abd_state_t state_next;
    abd_state_t state_upd;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] weak_reg;
    logic [63:0] strong_reg;

    logic out_free;
    logic step_fire;
    logic load_result;

    abd_update u_update
    (
        .state_cur (state_reg),
        .data_byte (byte_reg),
        .state_upd (state_upd)
    );

    assign out_free    = !out_valid_reg || out_ready;
    assign step_fire   = in_valid_reg && (!end_reg || out_free);
    assign load_result = step_fire && end_reg;
    assign in_ready    = !in_valid_reg || step_fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end

        state_next = state_reg;
        if (step_fire)
        begin
            state_next = end_reg ? STATE_INIT : state_upd;
        end

        out_valid_next = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_INIT;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= data_byte;
            end_reg  <= block_end;
        end
        if (load_result)
        begin
            weak_reg   <= {state_upd.high_sum, state_upd.low_sum};
            strong_reg <= state_upd.fnv_state;
        end
    end

    assign out_valid     = out_valid_reg;
    assign weak_checksum = weak_reg;
    assign strong_hash   = strong_reg;

endmodule

// ===== hdl/abd_checker.sv =====
// ---------------------------------------------------------------------------
// abd_checker
// Port-level checks on the block digest, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module abd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] weak_checksum,
    input logic [63:0] strong_hash
);
    import abd_pkg::*;

    `AST_SAME(a_low_sum_range, out_valid, weak_checksum[15:0] < ADLER_MOD)
    `AST_SAME(a_high_sum_range, out_valid, weak_checksum[31:16] < ADLER_MOD)
    `AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `AST_NEXT(a_out_stable, out_valid && !out_ready, $stable(weak_checksum) && $stable(strong_hash))

endmodule

bind block_adler_fnv_digest_top abd_checker u_abd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .weak_checksum (weak_checksum),
    .strong_hash   (strong_hash)
);
